// File: hw/rtl/fat_chain_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FCA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FCA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/fca_pkg.sv
// Shared types, codes and widths of the allocation table block.
// No dependencies; used by every module of the block.
`default_nettype none

package fca_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned BLOCK_W  = 7;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned DEF_NUM_BLOCKS       = 128;
  localparam int unsigned DEF_FIRST_DATA_BLOCK = 3;

  // Stream packing.
  localparam int unsigned TUSER_W      = OP_W;
  localparam int unsigned IN_FIELDS_W  = BLOCK_W + ENTRY_W;
  localparam int unsigned TDATA_IN_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + BLOCK_W + ENTRY_W + 4;
  localparam int unsigned TDATA_OUT_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = TDATA_OUT_W - OUT_FIELDS_W;
  localparam int unsigned IN_PAD_W     = TDATA_IN_W - IN_FIELDS_W;

  // Request codes.
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_TRUNC  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WALK  = 2'd3;

  // Entry codes.
  localparam logic [ENTRY_W-1:0] CODE_EMPTY   = 8'd0;
  localparam logic [ENTRY_W-1:0] CODE_END     = 8'd255;
  localparam logic [ENTRY_W-1:0] CODE_DAMAGED = 8'd254;

  typedef struct packed {
    logic is_empty;
    logic is_end;
    logic is_damaged;
    logic is_link;
  } cls_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  block_id;
    logic [ENTRY_W-1:0]  entry;
    logic                is_empty;
    logic                is_last;
    logic                is_damaged;
    logic                is_allocated;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/fca_fat_mem.sv
// Table storage: one write port, one registered read port, write data forwarded.
// Depends on fca_pkg for the entry width.
`default_nettype none

module fca_fat_mem #(
  parameter int unsigned NUM_BLOCKS = fca_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned AW         = $clog2(NUM_BLOCKS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [fca_pkg::ENTRY_W-1:0]  wdata_i,
  input  wire logic [AW-1:0]                raddr_i,
  output      logic [fca_pkg::ENTRY_W-1:0]  rdata_o
);
  import fca_pkg::*;

  logic [ENTRY_W-1:0] mem_q [NUM_BLOCKS];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Forward a same-cycle write so a read never sees stale data.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/fca_entry_cls.sv
// Shared compare unit: classifies one table entry against the codes and range.
// Depends on fca_pkg for the entry codes and cls_t.
`default_nettype none

module fca_entry_cls #(
  parameter int unsigned NUM_BLOCKS       = fca_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned FIRST_DATA_BLOCK = fca_pkg::DEF_FIRST_DATA_BLOCK
) (
  input  wire logic [fca_pkg::ENTRY_W-1:0] entry_i,
  output      fca_pkg::cls_t               cls_o
);
  import fca_pkg::*;

  localparam logic [ENTRY_W-1:0] NB_E  = ENTRY_W'(NUM_BLOCKS);
  localparam logic [ENTRY_W-1:0] FDB_E = ENTRY_W'(FIRST_DATA_BLOCK);

  always_comb begin
    cls_o.is_empty   = (entry_i == CODE_EMPTY);
    cls_o.is_end     = (entry_i == CODE_END);
    cls_o.is_damaged = (entry_i == CODE_DAMAGED);
    cls_o.is_link    = (entry_i >= FDB_E) && (entry_i < NB_E);
  end

endmodule

`default_nettype wire

// File: hw/rtl/fca_seq.sv
// Request sequencer: clearing pass, chain walks, free scan and table updates.
// Depends on fca_pkg and fat_chain_allocator_assert.svh.
`default_nettype none
`include "fat_chain_allocator_assert.svh"

module fca_seq #(
  parameter int unsigned NUM_BLOCKS       = fca_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned FIRST_DATA_BLOCK = fca_pkg::DEF_FIRST_DATA_BLOCK,
  parameter int unsigned AW               = $clog2(NUM_BLOCKS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [fca_pkg::OP_W-1:0]     op_i,
  input  wire logic [fca_pkg::BLOCK_W-1:0]  block_i,
  input  wire logic [fca_pkg::ENTRY_W-1:0]  value_i,
  output      logic                         ready_o,
  output      logic                         done_o,
  output      fca_pkg::res_t                res_o,
  input  wire logic                         ack_i,
  output      logic                         mem_we_o,
  output      logic [AW-1:0]                mem_waddr_o,
  output      logic [fca_pkg::ENTRY_W-1:0]  mem_wdata_o,
  output      logic [AW-1:0]                mem_raddr_o,
  input  wire logic [fca_pkg::ENTRY_W-1:0]  mem_rdata_i,
  input  wire fca_pkg::cls_t                cls_i
);
  import fca_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDENT = 4'd2;
  localparam logic [3:0] S_FREE  = 4'd3;
  localparam logic [3:0] S_TAIL  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_CUT   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [AW-1:0]      LAST_IDX  = AW'(NUM_BLOCKS - 1);
  localparam logic [AW-1:0]      FIRST_IDX = AW'(FIRST_DATA_BLOCK);
  localparam logic [ENTRY_W-1:0] NB_E      = ENTRY_W'(NUM_BLOCKS);
  localparam logic [ENTRY_W-1:0] FDB_E     = ENTRY_W'(FIRST_DATA_BLOCK);

  logic [3:0]      state_q, state_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   steps_q, steps_d;
  logic [AW-1:0]   blk_q, blk_d;
  logic [AW-1:0]   tail_q, tail_d;
  logic [OP_W-1:0] op_q, op_d;
  res_t            res_q, res_d;

  logic               blk_ok;
  logic [AW-1:0]      link_addr;
  logic [ENTRY_W-1:0] block_e;

  assign block_e   = ENTRY_W'(block_i);
  assign blk_ok    = (block_e >= FDB_E) && (block_e < NB_E);
  assign link_addr = AW'(mem_rdata_i);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    steps_d     = steps_q;
    blk_d       = blk_q;
    tail_d      = tail_q;
    op_d        = op_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = CODE_EMPTY;

    unique case (state_q)
      S_CLR: begin
        mem_we_o = 1'b1;
        if (ptr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          blk_d   = AW'(block_i);
          steps_d = '0;
          res_d   = '0;
          priority if (op_i == OP_ALLOC) begin
            ptr_d   = FIRST_IDX;
            state_d = S_SCAN;
          end else if (op_i > OP_WRITE) begin
            state_d = S_DONE;
          end else if (!blk_ok) begin
            res_d.status = ST_RANGE;
            state_d      = S_DONE;
          end else if (op_i == OP_FREE) begin
            ptr_d   = AW'(block_i);
            state_d = S_FREE;
          end else if ((op_i == OP_APPEND) || (op_i == OP_TRUNC)) begin
            ptr_d   = AW'(block_i);
            state_d = S_TAIL;
          end else if (op_i == OP_READ) begin
            ptr_d   = AW'(block_i);
            state_d = S_RDENT;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(block_i);
            mem_wdata_o = value_i;
            state_d     = S_DONE;
          end
        end
      end
      S_RDENT: begin
        res_d.entry        = mem_rdata_i;
        res_d.is_empty     = cls_i.is_empty;
        res_d.is_last      = cls_i.is_end;
        res_d.is_damaged   = cls_i.is_damaged;
        res_d.is_allocated = !(cls_i.is_empty || cls_i.is_end || cls_i.is_damaged);
        state_d            = S_DONE;
      end
      S_FREE: begin
        if (cls_i.is_empty) begin
          state_d = S_DONE;
        end else begin
          mem_we_o = 1'b1;
          priority if (cls_i.is_end) begin
            state_d = S_DONE;
          end else if (!cls_i.is_link || (steps_q == LAST_IDX)) begin
            res_d.status = ST_WALK;
            state_d      = S_DONE;
          end else begin
            ptr_d   = link_addr;
            steps_d = steps_q + AW'(1);
          end
        end
      end
      S_TAIL: begin
        priority if (cls_i.is_end) begin
          tail_d = ptr_q;
          if (op_q == OP_APPEND) begin
            ptr_d   = FIRST_IDX;
            state_d = S_SCAN;
          end else begin
            ptr_d   = blk_q;
            state_d = S_CUT;
          end
        end else if (!cls_i.is_link || (steps_q == LAST_IDX)) begin
          res_d.status = ST_WALK;
          state_d      = S_DONE;
        end else begin
          ptr_d   = link_addr;
          steps_d = steps_q + AW'(1);
        end
      end
      S_SCAN: begin
        priority if (cls_i.is_empty) begin
          mem_we_o       = 1'b1;
          mem_wdata_o    = CODE_END;
          res_d.block_id = BLOCK_W'(ptr_q);
          state_d        = (op_q == OP_APPEND) ? S_LINK : S_DONE;
        end else if (ptr_q == LAST_IDX) begin
          res_d.status = ST_FULL;
          state_d      = S_DONE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_LINK: begin
        // ptr still holds the freshly allocated block
        mem_we_o    = 1'b1;
        mem_waddr_o = tail_q;
        mem_wdata_o = ENTRY_W'(ptr_q);
        state_d     = S_DONE;
      end
      S_CUT: begin
        mem_we_o = (ptr_q != blk_q);
        if (cls_i.is_end) begin
          state_d = S_FIN;
        end else begin
          ptr_d = link_addr;
        end
      end
      S_FIN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = blk_q;
        mem_wdata_o = CODE_END;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_raddr_o = ptr_d;
  assign ready_o     = (state_q == S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    blk_q   <= blk_d;
    tail_q  <= tail_d;
    op_q    <= op_d;
    res_q   <= res_d;
  end

  `FCA_ASSERT_IMPL(a_wr_in_range, mem_we_o, mem_waddr_o <= LAST_IDX, "table write out of range")
  `FCA_ASSERT_IMPL(a_start_idle, start_i, state_q == S_IDLE, "request taken while busy")
  `FCA_ASSERT_IMPL(a_cut_on_chain, state_q == S_CUT, cls_i.is_end || cls_i.is_link, "cut left a checked chain")
  `FCA_ASSERT_NEXT(a_ack_idle, ack_i, state_q == S_IDLE, "no return to idle after hand-over")
  `FCA_ASSERT_NEXT(a_done_hold, (state_q == S_DONE) && !ack_i, (state_q == S_DONE) && $stable(res_q), "result lost before hand-over")

endmodule

`default_nettype wire

// File: hw/rtl/fat_chain_allocator.sv
// Top level of the file allocation table chain manager.
// Depends on fca_pkg, fca_fat_mem, fca_entry_cls and fca_seq.
//
// Usage:
//   Requests arrive on the s_axis channel, one transfer per request; the op code
//   rides in tuser, block and value in tdata. Each request yields exactly one
//   result transfer on m_axis carrying status, allocated block, entry and flags.
//   Requests are served one at a time: s_axis_tready is high only while the
//   sequencer is idle. Every table visit goes through the single read port of
//   the table memory, so a request lasts longer the more entries it visits:
//   write visits none, read one, allocate scans the data area for an empty entry,
//   free walks the chain, append walks the chain and then does the free scan,
//   truncate walks the chain twice.
//   After reset the table is cleared to empty by a pass over every entry,
//   during which no request is taken.
//   The finished result sits in an output register; if the receiver stalls it
//   is held there, and a following request may be taken and worked on, but its
//   result waits in the sequencer until the output register drains.
`default_nettype none

module fat_chain_allocator #(
  parameter int unsigned NUM_BLOCKS       = fca_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned FIRST_DATA_BLOCK = fca_pkg::DEF_FIRST_DATA_BLOCK
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [6:0] block, [14:7] value, [15] zero
  input  wire logic [fca_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // [2:0] op
  input  wire logic [fca_pkg::TUSER_W-1:0]       s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] status, [8:2] block_id, [16:9] entry, [17] is_empty, [18] is_last,
  // [19] is_damaged, [20] is_allocated, [23:21] zero
  output      logic [fca_pkg::TDATA_OUT_W-1:0]   m_axis_tdata
);
  import fca_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BLOCKS);

  logic               start;
  logic               seq_ready;
  logic               seq_done;
  logic               ack;
  res_t               seq_res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  cls_t               cls;

  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  // A transfer in starts the sequencer.
  assign s_axis_tready = seq_ready;
  assign start         = s_axis_tvalid && seq_ready;

  fca_fat_mem #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // One classifier serves every walk, scan and read.
  fca_entry_cls #(
    .NUM_BLOCKS       (NUM_BLOCKS),
    .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK)
  ) u_cls (
    .entry_i (mem_rdata),
    .cls_o   (cls)
  );

  fca_seq #(
    .NUM_BLOCKS       (NUM_BLOCKS),
    .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK),
    .AW               (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (s_axis_tuser[OP_W-1:0]),
    .block_i     (s_axis_tdata[BLOCK_W-1:0]),
    .value_i     (s_axis_tdata[BLOCK_W +: ENTRY_W]),
    .ready_o     (seq_ready),
    .done_o      (seq_done),
    .res_o       (seq_res),
    .ack_i       (ack),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .cls_i       (cls)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign ack = seq_done && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (ack) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_res_q <= seq_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                          out_res_q.is_allocated,
                          out_res_q.is_damaged,
                          out_res_q.is_last,
                          out_res_q.is_empty,
                          out_res_q.entry,
                          out_res_q.block_id,
                          out_res_q.status};

endmodule

`default_nettype wire

// File: tb/fat_table_checker.sv
// Result checker for fat_chain_allocator: watches both stream channels, keeps its
// own copy of the allocation table and compares every result field by field.
// Depends on fca_pkg.
module fat_table_checker #(
  parameter int unsigned NUM_BLOCKS       = fca_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned FIRST_DATA_BLOCK = fca_pkg::DEF_FIRST_DATA_BLOCK
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [fca_pkg::TDATA_IN_W-1:0]  s_tdata_i,
  input  logic [fca_pkg::TUSER_W-1:0]     s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [fca_pkg::TDATA_OUT_W-1:0] m_tdata_i,
  output int unsigned                     pending_o,
  output int unsigned                     faults_o
);
  import fca_pkg::*;

  localparam int unsigned BID_LSB    = STATUS_W;
  localparam int unsigned ENT_LSB    = STATUS_W + BLOCK_W;
  localparam int unsigned FLG_LSB    = ENT_LSB + ENTRY_W;
  localparam int unsigned REPORT_MAX = 10;

  logic [ENTRY_W-1:0] shadow_fat [NUM_BLOCKS];
  res_t               awaited_q [$];
  res_t               seen;
  res_t               want;
  int unsigned        queued = 0;
  int unsigned        faults = 0;

  assign pending_o = queued;
  assign faults_o  = faults;

  function automatic bit data_index(int unsigned idx);
    return idx >= FIRST_DATA_BLOCK && idx < NUM_BLOCKS;
  endfunction

  function automatic bit lowest_free(output int unsigned slot);
    slot = 0;
    for (int unsigned i = FIRST_DATA_BLOCK; i < NUM_BLOCKS; i++) begin
      if (shadow_fat[i] == CODE_EMPTY) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Follow links from head to the end code; any bad link or too many hops fails.
  function automatic logic [STATUS_W-1:0] chain_tail(int unsigned head,
                                                     output int unsigned tail);
    int unsigned        at;
    logic [ENTRY_W-1:0] link;
    at   = head;
    tail = 0;
    for (int unsigned hop = 0; hop < NUM_BLOCKS; hop++) begin
      link = shadow_fat[at];
      if (link == CODE_END) begin
        tail = at;
        return ST_OK;
      end
      if (!data_index(link)) return ST_WALK;
      at = link;
    end
    return ST_WALK;
  endfunction

  // Clear a chain; entries cleared before a bad link stay cleared.
  function automatic logic [STATUS_W-1:0] release_chain(int unsigned head);
    int unsigned        at;
    logic [ENTRY_W-1:0] link;
    at = head;
    for (int unsigned hop = 0; hop < NUM_BLOCKS; hop++) begin
      link = shadow_fat[at];
      if (link == CODE_EMPTY) return ST_OK;
      shadow_fat[at] = CODE_EMPTY;
      if (link == CODE_END) return ST_OK;
      if (!data_index(link)) return ST_WALK;
      at = link;
    end
    return ST_WALK;
  endfunction

  function automatic res_t apply_request(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] blk,
                                         logic [ENTRY_W-1:0] val);
    res_t               r;
    int unsigned        slot;
    int unsigned        tail;
    int unsigned        hop;
    logic [ENTRY_W-1:0] link;
    logic [ENTRY_W-1:0] nxt;
    r = '0;
    if (op == OP_ALLOC) begin
      if (lowest_free(slot)) begin
        shadow_fat[slot] = CODE_END;
        r.block_id = slot[BLOCK_W-1:0];
      end else begin
        r.status = ST_FULL;
      end
    end else if (op <= OP_WRITE && !data_index(blk)) begin
      r.status = ST_RANGE;
    end else begin
      case (op)
        OP_FREE: r.status = release_chain(blk);
        OP_APPEND: begin
          r.status = chain_tail(blk, tail);
          if (r.status == ST_OK) begin
            if (lowest_free(slot)) begin
              shadow_fat[slot] = CODE_END;
              shadow_fat[tail] = slot[ENTRY_W-1:0];
              r.block_id = slot[BLOCK_W-1:0];
            end else begin
              r.status = ST_FULL;
            end
          end
        end
        OP_TRUNC: begin
          r.status = chain_tail(blk, tail);
          if (r.status == ST_OK) begin
            link = shadow_fat[blk];
            hop  = 0;
            while (hop < NUM_BLOCKS && link != CODE_END && data_index(link)) begin
              nxt              = shadow_fat[link];
              shadow_fat[link] = CODE_EMPTY;
              link             = nxt;
              hop++;
            end
            shadow_fat[blk] = CODE_END;
          end
        end
        OP_READ: begin
          r.entry        = shadow_fat[blk];
          r.is_empty     = r.entry == CODE_EMPTY;
          r.is_last      = r.entry == CODE_END;
          r.is_damaged   = r.entry == CODE_DAMAGED;
          r.is_allocated = !(r.is_empty || r.is_last || r.is_damaged);
        end
        OP_WRITE: shadow_fat[blk] = val;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic note_fault(input bit orphan);
    faults++;
    if (faults <= REPORT_MAX) begin
      if (orphan) begin
        $display("%0t: result with nothing outstanding: status %0d block_id %0d entry %0d",
                 $realtime, seen.status, seen.block_id, seen.entry);
      end else begin
        $display("%0t: result mismatch (expected/actual) status %0d/%0d block_id %0d/%0d",
                 $realtime, want.status, seen.status, want.block_id, seen.block_id);
        $display("  entry %0d/%0d flags empty,last,damaged,allocated %b/%b",
                 want.entry, seen.entry,
                 {want.is_empty, want.is_last, want.is_damaged, want.is_allocated},
                 {seen.is_empty, seen.is_last, seen.is_damaged, seen.is_allocated});
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_BLOCKS; i++) shadow_fat[i] = CODE_EMPTY;
      awaited_q.delete();
      queued = 0;
    end else begin
      // Results belong to older requests, so retire them before taking a new one.
      if (m_tvalid_i && m_tready_i) begin
        seen.status       = m_tdata_i[0 +: STATUS_W];
        seen.block_id     = m_tdata_i[BID_LSB +: BLOCK_W];
        seen.entry        = m_tdata_i[ENT_LSB +: ENTRY_W];
        seen.is_empty     = m_tdata_i[FLG_LSB];
        seen.is_last      = m_tdata_i[FLG_LSB + 1];
        seen.is_damaged   = m_tdata_i[FLG_LSB + 2];
        seen.is_allocated = m_tdata_i[FLG_LSB + 3];
        if (awaited_q.size() == 0) begin
          note_fault(1'b1);
        end else begin
          want = awaited_q.pop_front();
          if (seen.status != want.status || seen.block_id != want.block_id ||
              seen.entry != want.entry || seen.is_empty != want.is_empty ||
              seen.is_last != want.is_last || seen.is_damaged != want.is_damaged ||
              seen.is_allocated != want.is_allocated)
            note_fault(1'b0);
        end
      end
      if (s_tvalid_i && s_tready_i)
        awaited_q.push_back(apply_request(s_tuser_i[OP_W-1:0], s_tdata_i[BLOCK_W-1:0],
                                          s_tdata_i[BLOCK_W +: ENTRY_W]));
      queued = awaited_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the fat_chain_allocator testbench: clock, reset, request and result
// stream drivers, watchdog and verdict. Depends on fca_pkg, the block's RTL
// and fat_table_checker.
module tb_top;
  import fca_pkg::*;

  localparam int unsigned NB          = DEF_NUM_BLOCKS;
  localparam int unsigned FDB         = DEF_FIRST_DATA_BLOCK;
  localparam int unsigned ITEM_GOAL   = 600;
  localparam int unsigned GAP_MAX     = 11;
  // Long receiver hold-off, well beyond what two buffered results take.
  localparam int unsigned RX_HOLD     = 500;
  // Cycles to sit idle at the end: about one worst-case request.
  localparam int unsigned SETTLE      = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 6000;

  // Op codes the block leaves undefined: answered with a plain ok.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [6:0] block, [14:7] value, [15] zero
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  // [2:0] op
  logic [TUSER_W-1:0]     s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [1:0] status, [8:2] block_id, [16:9] entry, [17] is_empty, [18] is_last,
  // [19] is_damaged, [20] is_allocated, [23:21] zero
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  int unsigned        pending;
  int unsigned        faults;
  int unsigned        sent     = 0;
  int unsigned        quiet    = 0;
  int unsigned        span     = 12;
  bit                 tx_lazy  = 1'b1;
  bit                 rx_hold  = 1'b0;
  logic [BLOCK_W-1:0] last_bid = '0;

  always #4 clk_i = ~clk_i;

  fat_chain_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  fat_table_checker #(
    .NUM_BLOCKS      (NB),
    .FIRST_DATA_BLOCK(FDB)
  ) checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .pending_o (pending),
    .faults_o  (faults)
  );

  // Remember the block handed out by the latest result, so that chain
  // sequences can target the head they have just allocated.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) last_bid <= m_axis_tdata[STATUS_W +: BLOCK_W];
  end

  // Watchdog: count cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request: idle for a random gap when the sequence is lazy, drive
  // at the falling edge, hold until the transfer completes at a rising edge.
  task automatic send_req(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] blk,
                          logic [ENTRY_W-1:0] val);
    int unsigned gap;
    gap = tx_lazy ? $urandom_range(0, GAP_MAX) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {{IN_PAD_W{1'b0}}, val, blk};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return OP_ALLOC;
    if (roll < 30) return OP_FREE;
    if (roll < 50) return OP_APPEND;
    if (roll < 60) return OP_TRUNC;
    if (roll < 80) return OP_READ;
    if (roll < 97) return OP_WRITE;
    return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  // Mostly blocks in the busy window just above the reserved ones, where
  // chains actually live; now and then a reserved index or anything at all.
  function automatic logic [BLOCK_W-1:0] pick_block();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(0, FDB - 1);
    if (roll < 15) return $urandom_range(0, NB - 1);
    return $urandom_range(FDB, FDB + span);
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return CODE_END;
    if (roll < 45) return CODE_DAMAGED;
    if (roll < 60) return CODE_EMPTY;
    if (roll < 85) return $urandom_range(FDB, FDB + span);
    return $urandom_range(0, 255);
  endfunction

  // Result side: a random stall before each result, with stretches of none,
  // and one long hold-off when the request side asks for it.
  initial begin
    int unsigned wait_n;
    int unsigned taken;
    bit          rx_lazy;
    taken   = 0;
    rx_lazy = 1'b1;
    forever begin
      if (taken % 40 == 0) rx_lazy = $urandom_range(0, 2) != 0;
      wait_n = rx_lazy ? $urandom_range(0, GAP_MAX) : 0;
      @(negedge clk_i);
      if (rx_hold) begin
        rx_hold = 1'b0;
        wait_n  = RX_HOLD;
      end
      if (wait_n != 0) begin
        m_axis_tready = 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Request side and verdict.
  initial begin
    int unsigned head;
    int unsigned roll;
    bit          long_done;
    bit          hold_done;
    long_done = 1'b0;
    hold_done = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: flags of every entry kind, chain building, the ok, range and walk statuses,
    // reserved indices, links that leave the table, a loop and the spare ops.
    send_req(OP_READ, FDB, 8'h00);
    send_req(OP_ALLOC, 0, 8'hFF);
    send_req(OP_ALLOC, NB - 1, 8'h00);
    send_req(OP_APPEND, FDB, 8'h5A);
    send_req(OP_APPEND, FDB, 8'hA5);
    send_req(OP_READ, FDB, 8'h00);
    send_req(OP_READ, FDB + 3, 8'h00);
    send_req(OP_WRITE, NB - 1, CODE_DAMAGED);
    send_req(OP_READ, NB - 1, 8'h00);
    send_req(OP_APPEND, NB - 1, 8'h00);
    send_req(OP_FREE, NB - 1, 8'h00);
    send_req(OP_READ, 0, 8'h00);
    send_req(OP_WRITE, FDB - 1, CODE_END);
    send_req(OP_TRUNC, FDB, 8'h00);
    send_req(OP_FREE, FDB + 1, 8'h00);
    send_req(OP_FREE, FDB + 20, 8'h00);
    // A block linked to itself: every walk from it runs out of steps.
    send_req(OP_WRITE, FDB + 20, FDB + 20);
    send_req(OP_APPEND, FDB + 20, 8'h00);
    send_req(OP_TRUNC, FDB + 20, 8'h00);
    // Links below the data area and past the end of the table.
    send_req(OP_WRITE, FDB + 21, 8'd1);
    send_req(OP_TRUNC, FDB + 21, 8'h00);
    send_req(OP_WRITE, FDB + 22, NB);
    send_req(OP_APPEND, FDB + 22, 8'h00);
    send_req(OP_SPARE_LO, NB - 1, 8'hFF);
    send_req(OP_SPARE_HI, 0, 8'h00);

    while (sent < ITEM_GOAL) begin
      roll    = $urandom_range(0, 99);
      tx_lazy = $urandom_range(0, 2) != 0;
      span    = $urandom_range(8, 40);
      if (!long_done && sent >= 250) begin
        // Grow one chain until the table is full, probe full, then free it.
        long_done = 1'b1;
        tx_lazy   = 1'b0;
        drain();
        send_req(OP_ALLOC, $urandom_range(0, NB - 1), $urandom_range(0, 255));
        drain();
        head = last_bid;
        repeat (NB) send_req(OP_APPEND, head, $urandom_range(0, 255));
        send_req(OP_ALLOC, $urandom_range(0, NB - 1), $urandom_range(0, 255));
        send_req(OP_FREE, head, $urandom_range(0, 255));
      end else if (roll < 55) begin
        if (!hold_done && sent >= 120) begin
          // Stall the result side while requests keep coming back to back.
          hold_done = 1'b1;
          tx_lazy   = 1'b0;
          rx_hold   = 1'b1;
          repeat (30) send_req(pick_op(), pick_block(), pick_value());
        end else begin
          repeat ($urandom_range(10, 30)) send_req(pick_op(), pick_block(), pick_value());
        end
      end else if (roll < 90) begin
        // Well-formed chain: quiesce, allocate a head, grow it, then cut it back, free it or damage an entry.
        drain();
        send_req(OP_ALLOC, $urandom_range(0, NB - 1), $urandom_range(0, 255));
        drain();
        head = last_bid;
        repeat ($urandom_range(2, 12)) begin
          send_req(OP_APPEND, head, $urandom_range(0, 255));
          if ($urandom_range(0, 2) == 0) send_req(OP_READ, pick_block(), $urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
          0: begin
            send_req(OP_TRUNC, head, $urandom_range(0, 255));
            send_req(OP_FREE, head, $urandom_range(0, 255));
          end
          1: send_req(OP_TRUNC, pick_block(), $urandom_range(0, 255));
          2: send_req(OP_FREE, head, $urandom_range(0, 255));
          default: begin
            send_req(OP_WRITE, pick_block(), CODE_DAMAGED);
            send_req(OP_APPEND, head, $urandom_range(0, 255));
            send_req(OP_FREE, head, $urandom_range(0, 255));
          end
        endcase
      end else begin
        // Noise: any op code, any index, any value.
        repeat ($urandom_range(3, 8))
          send_req($urandom_range(0, 7), $urandom_range(0, NB - 1), $urandom_range(0, 255));
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (faults == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
